FILE: hw/rtl/base64_stream_encoder_top_assert.svh
// assertion macros for the base64 stream encoder checker
// needs a clock named clk and a reset named rst where used
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// check that is off while reset is high
`define B64E_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("base64 encoder check failed");

// check that also covers the reset cycles
`define B64E_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("base64 encoder reset check failed");

`endif

FILE: hw/rtl/b64enc_pkg.sv
// shared types, constants and the character mapping function of the base64 encoder
// no dependencies
package b64enc_pkg;

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } out_item_t;

  // characters produced by one accepted byte
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            eot;
  } job_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return w + 8'h41;
    else if (v < 6'd52) return w + 8'h47;
    else if (v < 6'd62) return w - 8'd4;
    else if (v == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

endpackage

FILE: hw/rtl/b64enc_front.sv
// front end: accepts bytes, tracks group phase and leftover bits, builds jobs
// depends on b64enc_pkg
module b64enc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  b64enc_pkg::in_item_t byte_item,
  input  logic                q_full,
  output logic                q_push,
  output b64enc_pkg::job_t    q_job
);

  logic [3:0] pending;
  logic [3:0] pending_next;
  logic [1:0] phase;
  logic [1:0] phase_next;

  logic [7:0] b;
  logic [3:0] np;
  logic [1:0] nph;

  assign byte_stall = q_full;
  assign q_push     = byte_valid && !q_full;
  assign b          = byte_item.data_byte;

  always_comb begin
    q_job.chars    = '0;
    q_job.last_idx = 2'd0;
    q_job.eot      = byte_item.final_byte;
    unique case (phase)
      b64enc_pkg::PH1: begin
        q_job.chars[0] = b64enc_pkg::b64_char({pending[1:0], b[7:4]});
        np  = b[3:0];
        nph = b64enc_pkg::PH2;
      end
      b64enc_pkg::PH2: begin
        q_job.chars[0] = b64enc_pkg::b64_char({pending, b[7:6]});
        q_job.chars[1] = b64enc_pkg::b64_char(b[5:0]);
        q_job.last_idx = 2'd1;
        np  = 4'd0;
        nph = b64enc_pkg::PH0;
      end
      default: begin
        q_job.chars[0] = b64enc_pkg::b64_char(b[7:2]);
        np  = {2'b00, b[1:0]};
        nph = b64enc_pkg::PH1;
      end
    endcase

    // flush leftover bits and pad on the last byte of a message
    if (byte_item.final_byte) begin
      if (nph == b64enc_pkg::PH1) begin
        q_job.chars[1] = b64enc_pkg::b64_char({np[1:0], 4'b0000});
        q_job.chars[2] = b64enc_pkg::PAD_CHAR;
        q_job.chars[3] = b64enc_pkg::PAD_CHAR;
        q_job.last_idx = 2'd3;
      end else if (nph == b64enc_pkg::PH2) begin
        q_job.chars[1] = b64enc_pkg::b64_char({np, 2'b00});
        q_job.chars[2] = b64enc_pkg::PAD_CHAR;
        q_job.last_idx = 2'd2;
      end
      pending_next = 4'd0;
      phase_next   = b64enc_pkg::PH0;
    end else begin
      pending_next = np;
      phase_next   = nph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
      phase   <= b64enc_pkg::PH0;
    end else if (q_push) begin
      pending <= pending_next;
      phase   <= phase_next;
    end
  end

endmodule

FILE: hw/rtl/b64enc_queue.sv
// short job queue between the front end and the character serializer
// depends on b64enc_pkg
module b64enc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64enc_pkg::job_t push_job,
  output logic             full,
  input  logic             pop,
  output b64enc_pkg::job_t head_job,
  output logic             empty
);

  b64enc_pkg::job_t entries [b64enc_pkg::QDEPTH];

  logic [b64enc_pkg::QPTR_W-1:0] wr_ptr;
  logic [b64enc_pkg::QPTR_W-1:0] rd_ptr;
  logic [b64enc_pkg::QCNT_W-1:0] count;

  assign full     = (count == b64enc_pkg::QCNT_W'(b64enc_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == b64enc_pkg::QPTR_W'(b64enc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == b64enc_pkg::QPTR_W'(b64enc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/b64enc_back.sv
// back end: walks each job one character per cycle, while the output is not stalled, into the output register
// depends on b64enc_pkg
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  b64enc_pkg::job_t      head_job,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b64enc_pkg::out_item_t char_item
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !char_valid || !char_stall;
  assign at_last = (idx == head_job.last_idx);
  assign q_pop   = load && !q_empty && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idx        <= 2'd0;
    end else if (load) begin
      char_valid <= !q_empty;
      if (!q_empty) begin
        char_item.char_code   <= head_job.chars[idx];
        char_item.end_of_text <= head_job.eot && at_last;
        idx                   <= at_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/base64_stream_encoder_top.sv
// path: a byte's job goes into a queue entry, and its first character then into the output register
// throughput: one character per cycle out while char_stall is low; a byte gives one or two characters,
//   a final byte two to four; the two-entry queue takes a byte in any cycle in which it is not full
// reset: synchronous, clears group phase, leftover bits, queue and output valid
// top level of the base64 stream encoder; uses b64enc_pkg, front, queue, back
module base64_stream_encoder_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  b64enc_pkg::in_item_t  byte_item,
  output logic                  char_valid,
  input  logic                  char_stall,
  output b64enc_pkg::out_item_t char_item
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  b64enc_pkg::job_t push_job;
  b64enc_pkg::job_t head_job;

  b64enc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  b64enc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  b64enc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

endmodule

FILE: hw/rtl/b64enc_checker.sv
// port-level checks for the base64 stream encoder, bound to the top level
// depends on b64enc_pkg and base64_stream_encoder_top_assert.svh
`include "base64_stream_encoder_top_assert.svh"

module b64enc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  byte_valid,
  input logic                  byte_stall,
  input b64enc_pkg::in_item_t  byte_item,
  input logic                  char_valid,
  input logic                  char_stall,
  input b64enc_pkg::out_item_t char_item
);

  logic [7:0] c;
  logic       c_ok;
  assign c    = char_item.char_code;
  assign c_ok = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F ||
                c == b64enc_pkg::PAD_CHAR;

  // stalled character transaction keeps its payload
  `B64E_ASSERT(a_out_hold, char_valid && char_stall |=> char_valid && $stable(char_item))

  // stalled byte transaction keeps its payload
  `B64E_ASSERT(a_in_hold, byte_valid && byte_stall |=> byte_valid && $stable(byte_item))

  // only alphabet characters or pad leave the block
  `B64E_ASSERT(a_char_set, char_valid |-> c_ok)

  `B64E_ASSERT_RST(a_out_reset, rst |=> !char_valid)

  `B64E_ASSERT_RST(a_in_reset, rst |=> !byte_stall)

endmodule

bind base64_stream_encoder_top b64enc_checker u_b64enc_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_item  (byte_item),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_item  (char_item)
);
